// ===== hw/rtl/cdpa_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, command and status codes for the circular deque.
// No dependencies.
package cdpa_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int POS_W    = 6;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 6;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;
    localparam int S_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + OCC_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_COUNT      = 3'd2,
        CMD_READ       = 3'd3,
        CMD_WRITE      = 3'd4,
        CMD_REMOVE     = 3'd5,
        CMD_DUMP       = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

endpackage

// ===== hw/rtl/circular_deque_positional_access.sv =====
`timescale 1ns / 1ps
// Circular deque with positional access: ring store, sequencer and output register.
// Depends on cdpa_pkg.
//
// One transaction is taken at a time. Push, count, write and rejected commands
// load their result into the output register by way of the S_EXEC and S_RESP
// states; a read passes through S_RDWAIT between them. Remove of position p in
// a store of n elements walks the later elements through the ring memory, which
// has one read and one write port, at one element per cycle, then goes on to
// S_RESP. Dump reads its first element in S_EXEC and then loads one element per
// cycle from S_DUMP into the output register while the output is not stalled.
// The next transaction is accepted once the previous one has placed its last
// result in the output register. The ring memory has no reset; only entries
// inside the occupied range are ever used, though a dump of an empty store reads the head slot.
module circular_deque_positional_access (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [5:0] position, [37:6] value, upper bits unused
    input  logic [cdpa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] command
    input  logic [cdpa_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] data_out, [37:32] occupancy, upper bits zero
    output logic [cdpa_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [cdpa_pkg::STAT_W-1:0]     m_axis_tuser,
    output logic                            m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_REMOVE,
        S_DUMP,
        S_RESP
    } t_state;

    t_state                               r_state;
    logic [cdpa_pkg::CMD_W-1:0]           r_cmd;
    logic [cdpa_pkg::POS_W-1:0]           r_pos;
    logic [cdpa_pkg::DATA_W-1:0]          r_val;
    logic [cdpa_pkg::ADDR_W-1:0]          r_head;
    logic [cdpa_pkg::CNT_W-1:0]           r_count;
    logic [cdpa_pkg::CNT_W-1:0]           r_ridx;
    logic [cdpa_pkg::CNT_W-1:0]           r_widx;
    logic                                 r_wr_pend;
    cdpa_pkg::t_status                    r_res_status;
    logic [cdpa_pkg::DATA_W-1:0]          r_res_data;

    logic                                 r_m_valid;
    logic [cdpa_pkg::DATA_W-1:0]          r_m_data;
    logic [cdpa_pkg::OCC_W-1:0]           r_m_occ;
    cdpa_pkg::t_status                    r_m_status;
    logic                                 r_m_last;

    logic [cdpa_pkg::DATA_W-1:0]          mem [cdpa_pkg::CAPACITY];
    logic [cdpa_pkg::DATA_W-1:0]          r_rd_data;

    logic                                 mem_we;
    logic [cdpa_pkg::ADDR_W-1:0]          mem_waddr;
    logic [cdpa_pkg::DATA_W-1:0]          mem_wdata;
    logic                                 mem_re;
    logic [cdpa_pkg::ADDR_W-1:0]          mem_raddr;

    logic                                 out_free;
    logic                                 out_load;
    logic                                 full;
    logic                                 pos_ok;
    logic [cdpa_pkg::CNT_W-1:0]           pos_off;
    logic [cdpa_pkg::ADDR_W-1:0]          head_dec;
    logic [cdpa_pkg::CNT_W-1:0]           ridx_inc;
    logic                                 dump_last;

    function automatic logic [cdpa_pkg::ADDR_W-1:0] slot(
        input logic [cdpa_pkg::ADDR_W-1:0] head,
        input logic [cdpa_pkg::CNT_W-1:0]  off
    );
        logic [cdpa_pkg::SUM_W-1:0] s;
        s = cdpa_pkg::SUM_W'(head) + cdpa_pkg::SUM_W'(off);
        if (s >= cdpa_pkg::SUM_W'(cdpa_pkg::CAPACITY)) begin
            s = s - cdpa_pkg::SUM_W'(cdpa_pkg::CAPACITY);
        end
        return s[cdpa_pkg::ADDR_W-1:0];
    endfunction

    assign out_free  = !r_m_valid || m_axis_tready;
    assign out_load  = out_free && ((r_state == S_DUMP) || (r_state == S_RESP));
    assign full      = (r_count == cdpa_pkg::CNT_W'(cdpa_pkg::CAPACITY));
    assign pos_ok    = (r_pos != '0) &&
                       (cdpa_pkg::CMP_W'(r_pos) <= cdpa_pkg::CMP_W'(r_count));
    assign pos_off   = cdpa_pkg::CNT_W'(r_pos) - cdpa_pkg::CNT_W'(1);
    assign head_dec  = (r_head == '0) ? cdpa_pkg::ADDR_W'(cdpa_pkg::CAPACITY - 1)
                                      : r_head - cdpa_pkg::ADDR_W'(1);
    assign ridx_inc  = r_ridx + cdpa_pkg::CNT_W'(1);
    assign dump_last = (ridx_inc == r_count);

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = slot(r_head, r_count);
        mem_wdata = r_val;
        mem_re    = 1'b0;
        mem_raddr = slot(r_head, r_ridx);
        case (r_state)
            S_EXEC: begin
                case (r_cmd)
                    cdpa_pkg::CMD_PUSH_FRONT: begin
                        mem_we    = !full;
                        mem_waddr = head_dec;
                    end
                    cdpa_pkg::CMD_PUSH_BACK: begin
                        mem_we    = !full;
                    end
                    cdpa_pkg::CMD_READ: begin
                        mem_re    = pos_ok;
                        mem_raddr = slot(r_head, pos_off);
                    end
                    cdpa_pkg::CMD_WRITE: begin
                        mem_we    = pos_ok;
                        mem_waddr = slot(r_head, pos_off);
                    end
                    cdpa_pkg::CMD_DUMP: begin
                        mem_re    = 1'b1;
                        mem_raddr = r_head;
                    end
                    default: begin
                    end
                endcase
            end
            S_REMOVE: begin
                mem_we    = r_wr_pend;
                mem_waddr = slot(r_head, r_widx);
                mem_wdata = r_rd_data;
                mem_re    = (r_ridx < r_count);
            end
            S_DUMP: begin
                mem_re    = out_free && !dump_last;
                mem_raddr = slot(r_head, ridx_inc);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_wr_pend <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= s_axis_tuser;
                        r_pos   <= s_axis_tdata[cdpa_pkg::POS_W-1:0];
                        r_val   <= s_axis_tdata[cdpa_pkg::POS_W +: cdpa_pkg::DATA_W];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_data <= '0;
                    case (r_cmd)
                        cdpa_pkg::CMD_PUSH_FRONT: begin
                            r_state <= S_RESP;
                            if (full) begin
                                r_res_status <= cdpa_pkg::ST_FULL;
                            end else begin
                                r_res_status <= cdpa_pkg::ST_OK;
                                r_head       <= head_dec;
                                r_count      <= r_count + cdpa_pkg::CNT_W'(1);
                            end
                        end
                        cdpa_pkg::CMD_PUSH_BACK: begin
                            r_state <= S_RESP;
                            if (full) begin
                                r_res_status <= cdpa_pkg::ST_FULL;
                            end else begin
                                r_res_status <= cdpa_pkg::ST_OK;
                                r_count      <= r_count + cdpa_pkg::CNT_W'(1);
                            end
                        end
                        cdpa_pkg::CMD_READ: begin
                            if (pos_ok) begin
                                r_res_status <= cdpa_pkg::ST_OK;
                                r_state      <= S_RDWAIT;
                            end else begin
                                r_res_status <= cdpa_pkg::ST_RANGE;
                                r_state      <= S_RESP;
                            end
                        end
                        cdpa_pkg::CMD_WRITE: begin
                            r_state <= S_RESP;
                            if (pos_ok) begin
                                r_res_status <= cdpa_pkg::ST_OK;
                            end else begin
                                r_res_status <= cdpa_pkg::ST_RANGE;
                            end
                        end
                        cdpa_pkg::CMD_REMOVE: begin
                            if (pos_ok) begin
                                r_res_status <= cdpa_pkg::ST_OK;
                                r_ridx       <= cdpa_pkg::CNT_W'(r_pos);
                                r_wr_pend    <= 1'b0;
                                r_state      <= S_REMOVE;
                            end else begin
                                r_res_status <= cdpa_pkg::ST_RANGE;
                                r_state      <= S_RESP;
                            end
                        end
                        cdpa_pkg::CMD_DUMP: begin
                            if (r_count == '0) begin
                                r_res_status <= cdpa_pkg::ST_RANGE;
                                r_state      <= S_RESP;
                            end else begin
                                r_res_status <= cdpa_pkg::ST_OK;
                                r_ridx       <= '0;
                                r_state      <= S_DUMP;
                            end
                        end
                        default: begin
                            r_res_status <= cdpa_pkg::ST_OK;
                            r_state      <= S_RESP;
                        end
                    endcase
                end
                S_RDWAIT: begin
                    r_res_data <= r_rd_data;
                    r_state    <= S_RESP;
                end
                S_REMOVE: begin
                    // read offset i+1 while writing the previous read, from offset i, into offset i-1
                    if (r_ridx < r_count) begin
                        r_widx    <= r_ridx - cdpa_pkg::CNT_W'(1);
                        r_ridx    <= ridx_inc;
                        r_wr_pend <= 1'b1;
                    end else begin
                        r_wr_pend <= 1'b0;
                        if (!r_wr_pend) begin
                            r_count <= r_count - cdpa_pkg::CNT_W'(1);
                            r_state <= S_RESP;
                        end
                    end
                end
                S_DUMP: begin
                    if (out_free) begin
                        r_m_status <= cdpa_pkg::ST_OK;
                        r_m_data   <= r_rd_data;
                        r_m_occ    <= cdpa_pkg::OCC_W'(r_count);
                        r_m_last   <= dump_last;
                        if (dump_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ridx  <= ridx_inc;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_m_status <= r_res_status;
                        r_m_data   <= r_res_data;
                        r_m_occ    <= cdpa_pkg::OCC_W'(r_count);
                        r_m_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = cdpa_pkg::M_TDATA_W'({r_m_occ, r_m_data});
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tlast  = r_m_last;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for circular_deque_positional_access: directed corner cases, then
// random command streams, each result checked against a behavioral deque. Needs cdpa_pkg.
module testbench;
    import cdpa_pkg::*;

    localparam int LIMIT = 1000000;
    localparam int DRAIN_WAIT = 40;
    localparam int RANDOM_ITEMS = 250;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        bit                drain;
    } cmd_item_t;

    typedef struct {
        t_status           status;
        logic [DATA_W-1:0] data;
        logic [OCC_W-1:0]  occ;
        logic              last;
    } deque_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    cmd_item_t     cmd_queue[$];
    cmd_item_t     cur_cmd;
    deque_result_t pending_results[$];

    // behavioral deque
    logic [DATA_W-1:0] shadow_ring [CAPACITY];
    int                shadow_head = 0;
    int                shadow_count = 0;

    int planned_count = 0;
    int burst_left = 8;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int n_cycles = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_dumps = 0;
    int n_full = 0;
    int n_range = 0;

    circular_deque_positional_access i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    task automatic post_result(input t_status st, input logic [DATA_W-1:0] data,
                               input logic last);
        deque_result_t r;
        r.status = st;
        r.data   = data;
        r.occ    = shadow_count[OCC_W-1:0];
        r.last   = last;
        pending_results.push_back(r);
        if (st == ST_FULL) n_full++;
        if (st == ST_RANGE) n_range++;
    endtask

    task automatic deque_apply(input cmd_item_t it);
        int  p;
        int  k;
        bit  pos_ok;
        p = int'(it.pos);
        pos_ok = (p >= 1) && (p <= shadow_count);
        case (it.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (shadow_count >= CAPACITY) begin
                    post_result(ST_FULL, '0, 1'b1);
                end else begin
                    if (it.cmd == CMD_PUSH_FRONT) begin
                        shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
                        shadow_ring[shadow_head] = it.val;
                    end else begin
                        shadow_ring[(shadow_head + shadow_count) % CAPACITY] = it.val;
                    end
                    shadow_count++;
                    post_result(ST_OK, '0, 1'b1);
                end
            end
            CMD_READ: begin
                if (!pos_ok) post_result(ST_RANGE, '0, 1'b1);
                else post_result(ST_OK, shadow_ring[(shadow_head + p - 1) % CAPACITY], 1'b1);
            end
            CMD_WRITE: begin
                if (!pos_ok) begin
                    post_result(ST_RANGE, '0, 1'b1);
                end else begin
                    shadow_ring[(shadow_head + p - 1) % CAPACITY] = it.val;
                    post_result(ST_OK, '0, 1'b1);
                end
            end
            CMD_REMOVE: begin
                if (!pos_ok) begin
                    post_result(ST_RANGE, '0, 1'b1);
                end else begin
                    for (k = p - 1; k + 1 < shadow_count; k++)
                        shadow_ring[(shadow_head + k) % CAPACITY] =
                            shadow_ring[(shadow_head + k + 1) % CAPACITY];
                    shadow_count--;
                    post_result(ST_OK, '0, 1'b1);
                end
            end
            CMD_DUMP: begin
                n_dumps++;
                if (shadow_count == 0) begin
                    post_result(ST_RANGE, '0, 1'b1);
                end else begin
                    for (k = 0; k < shadow_count; k++)
                        post_result(ST_OK, shadow_ring[(shadow_head + k) % CAPACITY],
                                    k + 1 == shadow_count);
                end
            end
            default: post_result(ST_OK, '0, 1'b1);  // count and the unused code
        endcase
    endtask

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int pos,
                             input logic [DATA_W-1:0] val, input bit drain);
        cmd_item_t it;
        it.cmd   = cmd;
        it.pos   = pos[POS_W-1:0];
        it.val   = val;
        it.drain = drain;
        cmd_queue.push_back(it);
        if ((cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) && planned_count < CAPACITY)
            planned_count++;
        if (cmd == CMD_REMOVE && pos >= 1 && pos <= planned_count)
            planned_count--;
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_pos();
        if (planned_count > 0 && $urandom_range(0, 99) < 85)
            return $urandom_range(1, planned_count);
        return $urandom_range(0, 32);
    endfunction

    // sender: bursts with random gaps, optional hold until all results are back
    always @(posedge i_clk) begin : sender
        logic [S_TDATA_W-1:0] word;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                deque_apply(cur_cmd);
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_queue.size() > 0 &&
                             !(cmd_queue[0].drain && pending_results.size() > 0)) begin
                    cur_cmd = cmd_queue.pop_front();
                    word = '0;
                    word[POS_W-1:0] = cur_cmd.pos;
                    word[POS_W +: DATA_W] = cur_cmd.val;
                    s_axis_tdata  <= word;
                    s_axis_tuser  <= cur_cmd.cmd;
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern switches at random between four modes of tready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(50, 300);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : monitor
        deque_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d data %h occ %0d last %b", $time,
                         m_axis_tuser, m_axis_tdata[DATA_W-1:0],
                         m_axis_tdata[DATA_W +: OCC_W], m_axis_tlast);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             m_axis_tuser);
                    n_errors++;
                end
                if (m_axis_tdata[DATA_W-1:0] !== want.data) begin
                    $display("%0t: data_out expected %h got %h", $time, want.data,
                             m_axis_tdata[DATA_W-1:0]);
                    n_errors++;
                end
                if (m_axis_tdata[DATA_W +: OCC_W] !== want.occ) begin
                    $display("%0t: occupancy expected %0d got %0d", $time, want.occ,
                             m_axis_tdata[DATA_W +: OCC_W]);
                    n_errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last expected %b got %b", $time, want.last, m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        while (n_cycles < LIMIT) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
        $display("testbench: done, errors");
        $finish;
    end

    initial begin : stimulus
        int               i;
        int               mode;
        int               mode_left;
        int               r;
        int               push_w;
        int               rem_w;
        logic [CMD_W-1:0] c;
        mode = 0;
        mode_left = 0;

        // empty store, unused code, extremes, wrap of the head, removal at each end
        queue_cmd(CMD_DUMP, 0, '0, 1'b0);
        queue_cmd(CMD_READ, 1, '0, 1'b0);
        queue_cmd(CMD_REMOVE, 1, '0, 1'b0);
        queue_cmd(CMD_WRITE, 0, 32'h1111_2222, 1'b0);
        queue_cmd(CMD_COUNT, 32, 32'hffff_ffff, 1'b0);
        queue_cmd(CMD_UNUSED, 5, 32'hdead_beef, 1'b0);
        queue_cmd(CMD_PUSH_BACK, 0, 32'h7fff_ffff, 1'b0);
        queue_cmd(CMD_PUSH_FRONT, 63, 32'h8000_0000, 1'b0);
        queue_cmd(CMD_PUSH_BACK, 0, 32'h0000_0000, 1'b0);
        queue_cmd(CMD_PUSH_FRONT, 0, 32'hffff_ffff, 1'b0);
        queue_cmd(CMD_READ, 1, '0, 1'b0);
        queue_cmd(CMD_READ, 4, '0, 1'b0);
        queue_cmd(CMD_READ, 5, '0, 1'b0);
        queue_cmd(CMD_READ, 0, '0, 1'b0);
        queue_cmd(CMD_WRITE, 2, 32'h1234_5678, 1'b0);
        queue_cmd(CMD_WRITE, 4, 32'h55aa_55aa, 1'b0);
        queue_cmd(CMD_REMOVE, 2, '0, 1'b0);
        queue_cmd(CMD_REMOVE, 3, '0, 1'b0);
        queue_cmd(CMD_DUMP, 0, '0, 1'b0);
        queue_cmd(CMD_REMOVE, 1, '0, 1'b0);
        queue_cmd(CMD_COUNT, 0, '0, 1'b0);
        queue_cmd(CMD_DUMP, 0, '0, 1'b0);

        // fill to capacity, then overflow, full dump and edges of a full store
        i = 0;
        while (planned_count < CAPACITY) begin
            queue_cmd(($urandom_range(0, 1) == 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                      $urandom_range(0, 32), rand_value(), i == 0);
            i++;
        end
        queue_cmd(CMD_PUSH_BACK, 0, rand_value(), 1'b0);
        queue_cmd(CMD_PUSH_FRONT, 0, rand_value(), 1'b0);
        queue_cmd(CMD_READ, 32, '0, 1'b0);
        queue_cmd(CMD_WRITE, 32, rand_value(), 1'b0);
        queue_cmd(CMD_READ, 1, '0, 1'b0);
        queue_cmd(CMD_DUMP, 0, '0, 1'b0);
        queue_cmd(CMD_REMOVE, 32, '0, 1'b0);
        queue_cmd(CMD_REMOVE, 1, '0, 1'b0);
        queue_cmd(CMD_WRITE, 32, rand_value(), 1'b0);
        queue_cmd(CMD_READ, 32, '0, 1'b0);

        // random phases leaning toward filling, draining or neither
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(15, 40);
            end
            mode_left--;
            push_w = (mode == 0) ? 65 : (mode == 1) ? 10 : 30;
            rem_w  = (mode == 0) ? 5 : (mode == 1) ? 50 : 20;
            r = $urandom_range(0, 99);
            if (r < push_w) begin
                c = ($urandom_range(0, 1) == 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            end else if (r < push_w + rem_w) begin
                c = CMD_REMOVE;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 30) c = CMD_READ;
                else if (r < 55) c = CMD_WRITE;
                else if (r < 72) c = CMD_COUNT;
                else if (r < 96) c = CMD_DUMP;
                else c = CMD_UNUSED;
            end
            queue_cmd(c, rand_pos(), rand_value(), i == RANDOM_ITEMS / 2);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d commands (%0d dumps), checked %0d results in %0d cycles;",
                 n_sent, n_dumps, n_results, n_cycles);
        $display("saw %0d full-store and %0d out-of-range rejections, %0d mismatches.",
                 n_full, n_range, n_errors);
        if (n_errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cdpa_pkg.sv
hw/rtl/circular_deque_positional_access.sv
dv/testbench.sv
